// ===== hdl/assert_macros.svh =====
// assertion macros used by the mfv_core frame state machine
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MFV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define MFV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mfv_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the meter frame validator
// used by mfv_core and meter_frame_validator; no dependencies

package mfv_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 14;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [BYTE_W-1:0] START_CODE = 8'h68;
	localparam logic [BYTE_W-1:0] END_CODE = 8'h16;
	localparam logic [1:0] MARK_BITS = 2'b10;
	localparam logic [LEN_W-1:0] LEN_RESET = 14'h3FFF;

	// register index taken from the word address bit
	localparam logic REG_MAX_DATA_LEN = 1'b0;

	typedef enum logic [STAT_W-1:0] {
		ST_HUNT = 3'd0,
		ST_BUSY = 3'd1,
		ST_OK = 3'd2,
		ST_HEADER = 3'd3,
		ST_LONG = 3'd4,
		ST_ENDBAD = 3'd5,
		ST_SUMBAD = 3'd6
	} status_t;

	typedef enum logic [7:0] {
		PH_HUNT = 8'b0000_0001,
		PH_L1LO = 8'b0000_0010,
		PH_L1HI = 8'b0000_0100,
		PH_L2LO = 8'b0000_1000,
		PH_L2HI = 8'b0001_0000,
		PH_START2 = 8'b0010_0000,
		PH_DATA = 8'b0100_0000,
		PH_END = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic in_frame;
		logic frame_done;
		status_t status;
	} mfv_result_t;

endpackage

// ===== hdl/mfv_core.sv =====
`timescale 1ns / 1ps
// frame state machine: header, length, checksum and end code checks per byte
// depends on mfv_pkg and assert_macros.svh

`include "assert_macros.svh"

module mfv_core import mfv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [LEN_W-1:0]  max_data_len,
	output mfv_result_t       res
);

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] low_len_q, low_len_d;
	logic [LEN_W-1:0]  len1_q, len1_d;
	logic [LEN_W-1:0]  rem_q, rem_d;
	logic [BYTE_W-1:0] sum_q, sum_d;

	logic [15:0]      word;
	logic [LEN_W-1:0] word_len;
	logic             mark_ok;
	logic             is_start;
	status_t          st;
	logic             inf;
	logic             done;
	logic             err;
	logic             in_hunt;

	assign word = {rx_byte, low_len_q};
	assign word_len = word[15:2];
	assign mark_ok = (word[1:0] == MARK_BITS);
	assign is_start = (rx_byte == START_CODE);
	assign in_hunt = (phase_q == PH_HUNT);

	always_comb begin
		phase_d = phase_q;
		low_len_d = low_len_q;
		len1_d = len1_q;
		rem_d = rem_q;
		sum_d = sum_q;
		st = ST_BUSY;
		inf = 1'b1;
		done = 1'b0;
		case (phase_q)
			PH_L1LO: begin
				low_len_d = rx_byte;
				phase_d = PH_L1HI;
			end
			PH_L2LO: begin
				low_len_d = rx_byte;
				phase_d = PH_L2HI;
			end
			PH_L1HI: begin
				len1_d = word_len;
				if (!mark_ok) begin
					st = ST_HEADER;
				end else if (word_len > max_data_len) begin
					st = ST_LONG;
				end else begin
					phase_d = PH_L2LO;
				end
			end
			PH_L2HI: begin
				if (!mark_ok || word_len != len1_q) begin
					st = ST_HEADER;
				end else begin
					phase_d = PH_START2;
				end
			end
			PH_START2: begin
				if (!is_start) begin
					st = ST_HEADER;
				end else begin
					rem_d = len1_q;
					sum_d = '0;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rem_q != '0) begin
					sum_d = sum_q + rx_byte;
					rem_d = rem_q - LEN_W'(1);
				end else begin
					sum_d = sum_q - rx_byte;
					phase_d = PH_END;
				end
			end
			PH_END: begin
				if (rx_byte != END_CODE) begin
					st = ST_ENDBAD;
				end else if (sum_q != '0) begin
					st = ST_SUMBAD;
				end else begin
					st = ST_OK;
					done = 1'b1;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				if (is_start) begin
					phase_d = PH_L1LO;
				end else begin
					st = ST_HUNT;
					inf = 1'b0;
				end
			end
		endcase
		err = (st == ST_HEADER) || (st == ST_LONG) || (st == ST_ENDBAD) ||
			(st == ST_SUMBAD);
		if (err) begin
			// an erroring start byte opens a new frame
			phase_d = is_start ? PH_L1LO : PH_HUNT;
			inf = is_start;
		end
	end

	assign res.in_frame = inf;
	assign res.frame_done = done;
	assign res.status = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			low_len_q <= '0;
			len1_q <= '0;
			rem_q <= '0;
			sum_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			low_len_q <= low_len_d;
			len1_q <= len1_d;
			rem_q <= rem_d;
			sum_q <= sum_d;
		end
	end

	`MFV_ASSERT(a_done_ok, !res.frame_done || (res.status == ST_OK && res.in_frame), "done without ok")
	`MFV_ASSERT_NEXT(a_hunt_stays, step && in_hunt && !is_start, in_hunt, "left hunt without start")
	`MFV_ASSERT_NEXT(a_err_resync, step && err, in_hunt || phase_q == PH_L1LO, "no resync")
	`MFV_ASSERT_NEXT(a_hold, !step, $stable({phase_q, sum_q, rem_q}), "state moved without a beat")

endmodule

// ===== hdl/meter_frame_validator.sv =====
`timescale 1ns / 1ps
// Byte-serial validator for 0x68-framed meter messages. One byte is taken per clock while
// in_ready is high; each byte comes back as one result beat after the input register and
// then the result register, which captures the frame check result. Unless out_ready stalls,
// throughput is one beat per cycle, set by the single frame state register update per byte.
// The user writes max_data_len over the APB port at byte address 0 only while idle;
// the block does not enforce it. It depends on mfv_pkg and mfv_core.

module meter_frame_validator import mfv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  echo_byte,
	output logic               in_frame,
	output logic               frame_done,
	output logic [STAT_W-1:0]  status
);

	logic [LEN_W-1:0]  max_len_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	logic [BYTE_W-1:0] byte_s2;
	mfv_result_t       res_s2;
	mfv_result_t       res;
	logic              out_free;
	logic              adv;
	logic              reg_sel;

	// config register
	assign pready = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_MAX_DATA_LEN);
	assign prdata = reg_sel ? {{(PDATA_W-LEN_W){1'b0}}, max_len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LEN_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_len_q <= pwdata[LEN_W-1:0];
		end
	end

	// input register
	assign out_free = !valid_s2 || out_ready;
	assign adv = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	mfv_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.rx_byte      (byte_s1),
		.max_data_len (max_len_q),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_s2 <= byte_s1;
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign echo_byte = byte_s2;
	assign in_frame = res_s2.in_frame;
	assign frame_done = res_s2.frame_done;
	assign status = res_s2.status;

endmodule
